@@ rtl/pmt_pkg.sv @@
package pmt_pkg;

  localparam int DATA_BITS       = 32;
  localparam int ADDR_BITS       = 4;
  localparam int FLAG_PORT_BITS  = 4;
  localparam int DEF_MATCH_CHANNELS = 4;
  localparam int DEF_COUNT_BITS     = 32;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  localparam logic [ADDR_BITS-1:0] ADDR_FLAGS    = 4'd0;
  localparam logic [ADDR_BITS-1:0] ADDR_CONTROL  = 4'd1;
  localparam logic [ADDR_BITS-1:0] ADDR_COUNT    = 4'd2;
  localparam logic [ADDR_BITS-1:0] ADDR_PS_LIMIT = 4'd3;
  localparam logic [ADDR_BITS-1:0] ADDR_PS_COUNT = 4'd4;
  localparam logic [ADDR_BITS-1:0] ADDR_MATCH_CTL = 4'd5;
  localparam logic [ADDR_BITS-1:0] ADDR_MATCH0   = 4'd6;

  // bit positions within one channel's three match control bits
  localparam int MC_INT  = 0;
  localparam int MC_RST  = 1;
  localparam int MC_STOP = 2;

endpackage

@@ rtl/prescaled_match_timer_top.sv @@
// Prescaled match timer. Each request is a tick, a register write, a register read or
// a no-op; one request is taken every clock while in_stall is low, and its result (read
// data, irq and the flags after the request) is registered in the result register, or
// in the skid register if out_stall holds it. State is updated in the same edge that
// takes the request, so a tick, a write and a read can follow each other with no gap. A
// two-entry output buffer (result register plus skid register) lets one further request
// in while out_stall holds a result; in_stall rises only once both entries are full.
module prescaled_match_timer_top #(
  parameter int MATCH_CHANNELS = pmt_pkg::DEF_MATCH_CHANNELS,
  parameter int COUNT_BITS     = pmt_pkg::DEF_COUNT_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [pmt_pkg::ADDR_BITS-1:0]      addr,
  input  logic [pmt_pkg::DATA_BITS-1:0]      wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pmt_pkg::DATA_BITS-1:0]      rdata,
  output logic                               irq,
  output logic [pmt_pkg::FLAG_PORT_BITS-1:0] flags_now
);
  import pmt_pkg::*;

  localparam int MC_BITS = 3 * MATCH_CHANNELS;

  typedef struct packed {
    logic [DATA_BITS-1:0]      rdata;
    logic                      irq;
    logic [FLAG_PORT_BITS-1:0] flags;
  } result_t;

  logic [COUNT_BITS-1:0]     main_count, main_count_next;
  logic [COUNT_BITS-1:0]     prescale_count, prescale_count_next;
  logic [COUNT_BITS-1:0]     prescale_limit, prescale_limit_next;
  logic [COUNT_BITS-1:0]     match_value [MATCH_CHANNELS];
  logic [COUNT_BITS-1:0]     match_value_next [MATCH_CHANNELS];
  logic [MC_BITS-1:0]        match_control, match_control_next;
  logic [MATCH_CHANNELS-1:0] int_flags, int_flags_next;
  logic                      run_enable, run_enable_next;
  logic                      hold_reset, hold_reset_next;

  logic                      accept, out_take;
  logic                      do_reset, do_stop;
  logic [DATA_BITS-1:0]      rd_value;
  result_t                   res_new, res_out, res_skid;
  logic                      skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // state update for one request
  always_comb begin
    main_count_next     = main_count;
    prescale_count_next = prescale_count;
    prescale_limit_next = prescale_limit;
    match_value_next    = match_value;
    match_control_next  = match_control;
    int_flags_next      = int_flags;
    run_enable_next     = run_enable;
    hold_reset_next     = hold_reset;
    do_reset            = 1'b0;
    do_stop             = 1'b0;
    rd_value            = '0;

    unique case (func)
      FUNC_TICK: begin
        if (hold_reset) begin
          main_count_next     = '0;
          prescale_count_next = '0;
        end else if (run_enable) begin
          if (prescale_count != prescale_limit) begin
            prescale_count_next = prescale_count + COUNT_BITS'(1);
          end else begin
            prescale_count_next = '0;
            for (int i = 0; i < MATCH_CHANNELS; i++) begin
              if (main_count == match_value[i]) begin
                if (match_control[3*i+MC_INT]) int_flags_next[i] = 1'b1;
                if (match_control[3*i+MC_RST]) do_reset = 1'b1;
                if (match_control[3*i+MC_STOP]) do_stop = 1'b1;
              end
            end
            main_count_next = do_reset ? '0 : main_count + COUNT_BITS'(1);
            if (do_stop) run_enable_next = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        unique case (addr)
          ADDR_FLAGS:     int_flags_next = int_flags & ~wdata[MATCH_CHANNELS-1:0];
          ADDR_CONTROL: begin
            run_enable_next = wdata[0];
            hold_reset_next = wdata[1];
          end
          ADDR_COUNT:     main_count_next     = wdata[COUNT_BITS-1:0];
          ADDR_PS_LIMIT:  prescale_limit_next = wdata[COUNT_BITS-1:0];
          ADDR_PS_COUNT:  prescale_count_next = wdata[COUNT_BITS-1:0];
          ADDR_MATCH_CTL: match_control_next  = wdata[MC_BITS-1:0];
          default: begin
            for (int i = 0; i < MATCH_CHANNELS; i++) begin
              if (addr == ADDR_MATCH0 + ADDR_BITS'(i)) begin
                match_value_next[i] = wdata[COUNT_BITS-1:0];
              end
            end
          end
        endcase
      end
      FUNC_READ: begin
        unique case (addr)
          ADDR_FLAGS:     rd_value = DATA_BITS'(int_flags);
          ADDR_CONTROL:   rd_value = DATA_BITS'({hold_reset, run_enable});
          ADDR_COUNT:     rd_value = DATA_BITS'(main_count);
          ADDR_PS_LIMIT:  rd_value = DATA_BITS'(prescale_limit);
          ADDR_PS_COUNT:  rd_value = DATA_BITS'(prescale_count);
          ADDR_MATCH_CTL: rd_value = DATA_BITS'(match_control);
          default: begin
            for (int i = 0; i < MATCH_CHANNELS; i++) begin
              if (addr == ADDR_MATCH0 + ADDR_BITS'(i)) begin
                rd_value = DATA_BITS'(match_value[i]);
              end
            end
          end
        endcase
      end
      FUNC_NOP: ;
    endcase

    res_new.rdata = rd_value;
    res_new.irq   = |int_flags_next;
    res_new.flags = FLAG_PORT_BITS'(int_flags_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_count     <= '0;
      prescale_count <= '0;
      prescale_limit <= '0;
      for (int i = 0; i < MATCH_CHANNELS; i++) match_value[i] <= '0;
      match_control  <= '0;
      int_flags      <= '0;
      run_enable     <= 1'b0;
      hold_reset     <= 1'b0;
    end else if (accept) begin
      main_count     <= main_count_next;
      prescale_count <= prescale_count_next;
      prescale_limit <= prescale_limit_next;
      match_value    <= match_value_next;
      match_control  <= match_control_next;
      int_flags      <= int_flags_next;
      run_enable     <= run_enable_next;
      hold_reset     <= hold_reset_next;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        res_out    <= res_skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_take) begin
        res_out   <= res_new;
        out_valid <= 1'b1;
      end else begin
        res_skid   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign rdata     = res_out.rdata;
  assign irq       = res_out.irq;
  assign flags_now = res_out.flags;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in front");

  a_wait_goes_to_skid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !skid_valid && in_valid) |=> skid_valid)
    else $error("request taken while result stalled was not parked");

  a_hold_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_TICK && hold_reset)
      |=> (main_count == '0 && prescale_count == '0))
    else $error("tick under hold did not clear the counts");

  a_idle_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_TICK && !hold_reset && !run_enable) |=> $stable(main_count))
    else $error("count moved while disabled");

  a_flags_set_on_tick: assert property (@(posedge clk) disable iff (rst)
    (|(int_flags & ~$past(int_flags))) |-> $past(accept && func == FUNC_TICK))
    else $error("flag set by something other than a tick");

endmodule

@@ tb/sv/prescaled_match_timer_top_tb.sv @@
module prescaled_match_timer_top_tb;
  import pmt_pkg::*;

  localparam int CHANNELS     = DEF_MATCH_CHANNELS;
  localparam int RANDOM_ITEMS = 740;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic [DATA_BITS-1:0]      rdata;
    logic                      irq;
    logic [FLAG_PORT_BITS-1:0] flags;
  } timer_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                func;
  logic [ADDR_BITS-1:0]      addr;
  logic [DATA_BITS-1:0]      wdata;
  logic                      out_valid;
  logic                      out_stall;
  logic [DATA_BITS-1:0]      rdata;
  logic                      irq;
  logic [FLAG_PORT_BITS-1:0] flags_now;

  // predicted timer state
  logic [DATA_BITS-1:0]    tmr_count;
  logic [DATA_BITS-1:0]    tmr_ps_count;
  logic [DATA_BITS-1:0]    tmr_ps_limit;
  logic [DATA_BITS-1:0]    tmr_match [CHANNELS];
  logic [3*CHANNELS-1:0]   tmr_match_ctl;
  logic [CHANNELS-1:0]     tmr_flags;
  logic                    tmr_enable;
  logic                    tmr_hold;

  timer_result_t expected_results[$];
  bit            failed;
  bit            idle_on;
  int            hold_requests;
  int            hold_served;
  int            cycles;

  prescaled_match_timer_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .addr      (addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rdata     (rdata),
    .irq       (irq),
    .flags_now (flags_now)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("prescaled_match_timer_top_tb: FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one request to the predicted state and return its result.
  function automatic timer_result_t timer_step(func_t f, logic [ADDR_BITS-1:0] a,
                                               logic [DATA_BITS-1:0] d);
    timer_result_t r;
    logic          clear_count;
    logic          halt;
    logic [2:0]    ctl;
    r = '0;
    clear_count = 1'b0;
    halt = 1'b0;
    case (f)
      FUNC_TICK: begin
        if (tmr_hold) begin
          tmr_count = '0;
          tmr_ps_count = '0;
        end else if (tmr_enable) begin
          if (tmr_ps_count != tmr_ps_limit) begin
            tmr_ps_count = tmr_ps_count + 1;
          end else begin
            tmr_ps_count = '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (tmr_count == tmr_match[ch]) begin
                ctl = tmr_match_ctl[3*ch +: 3];
                if (ctl[MC_INT]) tmr_flags[ch] = 1'b1;
                if (ctl[MC_RST]) clear_count = 1'b1;
                if (ctl[MC_STOP]) halt = 1'b1;
              end
            end
            tmr_count = clear_count ? '0 : tmr_count + 1;
            if (halt) tmr_enable = 1'b0;
          end
        end
      end
      FUNC_WRITE: begin
        case (a)
          ADDR_FLAGS:     tmr_flags = tmr_flags & ~d[CHANNELS-1:0];
          ADDR_CONTROL: begin
            tmr_enable = d[0];
            tmr_hold = d[1];
          end
          ADDR_COUNT:     tmr_count = d;
          ADDR_PS_LIMIT:  tmr_ps_limit = d;
          ADDR_PS_COUNT:  tmr_ps_count = d;
          ADDR_MATCH_CTL: tmr_match_ctl = d[3*CHANNELS-1:0];
          default: begin
            if (a >= ADDR_MATCH0 && a < ADDR_MATCH0 + CHANNELS)
              tmr_match[a - ADDR_MATCH0] = d;
          end
        endcase
      end
      FUNC_READ: begin
        case (a)
          ADDR_FLAGS:     r.rdata = DATA_BITS'(tmr_flags);
          ADDR_CONTROL:   r.rdata = DATA_BITS'({tmr_hold, tmr_enable});
          ADDR_COUNT:     r.rdata = tmr_count;
          ADDR_PS_LIMIT:  r.rdata = tmr_ps_limit;
          ADDR_PS_COUNT:  r.rdata = tmr_ps_count;
          ADDR_MATCH_CTL: r.rdata = DATA_BITS'(tmr_match_ctl);
          default: begin
            if (a >= ADDR_MATCH0 && a < ADDR_MATCH0 + CHANNELS)
              r.rdata = tmr_match[a - ADDR_MATCH0];
          end
        endcase
      end
      default: ;
    endcase
    r.irq = |tmr_flags;
    r.flags = FLAG_PORT_BITS'(tmr_flags);
    return r;
  endfunction

  // Offer one request, hold it until taken, then predict its result.
  task automatic send_req(input func_t f, input logic [ADDR_BITS-1:0] a,
                          input logic [DATA_BITS-1:0] d);
    int   gap;
    logic taken;
    gap = (idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    addr <= a;
    wdata <= d;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    expected_results.push_back(timer_step(f, a, d));
  endtask

  // Result side: random stall bursts, plus long hold-offs on request.
  initial begin : result_stall
    int run;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        run = idle_len();
        out_stall <= 1'b1;
        repeat (run) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : result_check
    timer_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: rdata %h irq %b flags %b",
                   $time, rdata, irq, flags_now);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (rdata !== want.rdata) begin
            $display("%0t: rdata expected %h actual %h", $time, want.rdata, rdata);
            failed = 1'b1;
          end
          if (irq !== want.irq) begin
            $display("%0t: irq expected %b actual %b", $time, want.irq, irq);
            failed = 1'b1;
          end
          if (flags_now !== want.flags) begin
            $display("%0t: flags_now expected %b actual %b", $time, want.flags, flags_now);
            failed = 1'b1;
          end
        end
      end
    end
  end

  task automatic test_register_extremes();
    send_req(FUNC_READ, ADDR_FLAGS, '0);
    send_req(FUNC_WRITE, ADDR_BITS'(ADDR_MATCH0 + CHANNELS - 1), '1);
    send_req(FUNC_READ, ADDR_BITS'(ADDR_MATCH0 + CHANNELS - 1), '0);
    // upper match control bits belong to no channel: drop them
    send_req(FUNC_WRITE, ADDR_MATCH_CTL, '1);
    send_req(FUNC_READ, ADDR_MATCH_CTL, '1);
    send_req(FUNC_WRITE, 4'd15, '1);
    send_req(FUNC_READ, 4'd15, '1);
    send_req(FUNC_NOP, ADDR_COUNT, '1);
  endtask

  // Prescale count above the limit wraps round before the rollover;
  // the rollover then matches the last channel with all actions set.
  task automatic test_match_actions();
    send_req(FUNC_WRITE, ADDR_PS_LIMIT, 32'd2);
    send_req(FUNC_WRITE, ADDR_PS_COUNT, 32'hFFFF_FFFE);
    send_req(FUNC_WRITE, ADDR_COUNT, '1);
    send_req(FUNC_WRITE, ADDR_CONTROL, 32'd1);
    repeat (5) send_req(FUNC_TICK, '0, '0);
    send_req(FUNC_READ, ADDR_COUNT, '0);
    send_req(FUNC_READ, ADDR_CONTROL, '0);
    send_req(FUNC_WRITE, ADDR_FLAGS, '1);
  endtask

  task automatic test_count_wrap_and_hold();
    send_req(FUNC_WRITE, ADDR_MATCH_CTL, '0);
    send_req(FUNC_WRITE, ADDR_PS_LIMIT, '0);
    send_req(FUNC_WRITE, ADDR_CONTROL, 32'd1);
    send_req(FUNC_TICK, '1, '1);
    send_req(FUNC_READ, ADDR_COUNT, '0);
    send_req(FUNC_WRITE, ADDR_CONTROL, 32'd3);
    send_req(FUNC_TICK, '0, '0);
    send_req(FUNC_READ, ADDR_PS_COUNT, '0);
  endtask

  // Mostly programmed runs: count near the match values, a small prescale,
  // then a burst of ticks with reads and flag clears; the rest is noise.
  task automatic test_random_traffic();
    int                   n;
    int                   burst;
    int                   pick;
    logic [DATA_BITS-1:0] base;
    logic [DATA_BITS-1:0] limit;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 9) < 7) begin
        base = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                           : $urandom_range(0, 20);
        limit = $urandom_range(0, 3);
        send_req(FUNC_WRITE, ADDR_CONTROL, '0);
        send_req(FUNC_WRITE, ADDR_COUNT, base);
        for (int ch = 0; ch < CHANNELS; ch++)
          send_req(FUNC_WRITE, ADDR_BITS'(ADDR_MATCH0 + ch), base + $urandom_range(0, 12));
        send_req(FUNC_WRITE, ADDR_MATCH_CTL, $urandom);
        send_req(FUNC_WRITE, ADDR_PS_LIMIT, limit);
        send_req(FUNC_WRITE, ADDR_PS_COUNT, $urandom_range(0, limit));
        send_req(FUNC_WRITE, ADDR_CONTROL, ($urandom_range(0, 7) == 0) ? 32'd3 : 32'd1);
        burst = $urandom_range(10, 40);
        repeat (burst) begin
          pick = $urandom_range(0, 99);
          if (pick < 75) send_req(FUNC_TICK, ADDR_BITS'($urandom), $urandom);
          else if (pick < 90) send_req(FUNC_READ, ADDR_BITS'($urandom_range(0, 9)), $urandom);
          else send_req(FUNC_WRITE, ADDR_FLAGS, $urandom);
        end
        n += burst + CHANNELS + 6;
      end else begin
        repeat (10) send_req(func_t'($urandom_range(0, 3)), ADDR_BITS'($urandom), $urandom);
        n += 10;
      end
    end
  endtask

  // Hold the result side off while requests keep coming, so the block fills.
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_requests++;
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_req(FUNC_TICK, ADDR_BITS'($urandom), $urandom);
      else send_req(FUNC_READ, ADDR_BITS'($urandom_range(0, 9)), $urandom);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_TICK;
    addr <= '0;
    wdata <= '0;
    tmr_count = '0;
    tmr_ps_count = '0;
    tmr_ps_limit = '0;
    for (int ch = 0; ch < CHANNELS; ch++) tmr_match[ch] = '0;
    tmr_match_ctl = '0;
    tmr_flags = '0;
    tmr_enable = 1'b0;
    tmr_hold = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_register_extremes();
    test_match_actions();
    test_count_wrap_and_hold();
    test_backpressure();
    test_random_traffic();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failed) $display("prescaled_match_timer_top_tb: FAIL");
    else $display("prescaled_match_timer_top_tb: PASS");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pmt_pkg.sv
rtl/prescaled_match_timer_top.sv
tb/sv/prescaled_match_timer_top_tb.sv
